// ----- rtl/pmqm_pkg.sv -----
// Shared types, codes and pair tables of the point-mass quadrupole block.
`default_nettype none
package pmqm_pkg;

    // Result status codes.
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_ZERO_MASS = 2'd1;
    localparam logic [1:0] STAT_OVERFLOW  = 2'd2;

    localparam int POS_W  = 24;
    localparam int MASS_W = 24;
    localparam int SUM_W  = 32;
    localparam int WSUM_W = 56;
    localparam int QUAD_W = 58;
    localparam int OP_W   = 26;
    localparam int PROD_W = 52;

    // Destination of a multiplier result.
    typedef enum logic [3:0] {
        TAG_NONE,
        TAG_WX,
        TAG_WY,
        TAG_WZ,
        TAG_UX,
        TAG_UY,
        TAG_UZ,
        TAG_HI,
        TAG_LO
    } t_tag;

    typedef struct packed {
        t_tag              tag;
        logic [2:0]        pair;
        logic [OP_W-1:0]   op_a;
        logic [OP_W-1:0]   op_b;
    } t_mul_req;

    typedef struct packed {
        t_tag              tag;
        logic [2:0]        pair;
        logic [PROD_W-1:0] prod;
    } t_mul_rsp;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WMUL,
        ST_WDRAIN,
        ST_DIV,
        ST_QREAD,
        ST_QRUN,
        ST_QDRAIN,
        ST_FIN
    } t_state;

    // Axes of the six unique quadrupole components xx, xy, xz, yy, yz, zz.
    function automatic logic [1:0] pair_a(input logic [2:0] k);
        logic [1:0] r;
        case (k)
            3'd0, 3'd1, 3'd2: r = 2'd0;
            3'd3, 3'd4:       r = 2'd1;
            default:          r = 2'd2;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] pair_b(input logic [2:0] k);
        logic [1:0] r;
        case (k)
            3'd0:       r = 2'd0;
            3'd1, 3'd3: r = 2'd1;
            default:    r = 2'd2;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/point_mass_quadrupole_moment.sv -----
// Top level of the point-mass quadrupole moment block: loader, centroid and moment sequencer.
//
// Point masses stream in as items; each one that fits is stored in an on-chip buffer and folded into the
// total mass and the mass-weighted position sums. The item flagged by tlast closes the set: the
// centroid is then found by division truncated toward zero (saturated to 24 bits), and a second
// pass over the buffer sums mass * (p - c)(p - c)^T into six 58-bit components, each term floored
// to 12 fraction bits. A single result item carries total mass, centroid and quadrupole, with a
// status in tuser (zero total mass wins over buffer overflow). All products go through one shared
// 26 x 26 multiplier: a stored point holds the input off while its three weighted products are
// issued and a drain state follows, whereas a dropped point that does not close the set does not.
// The closing pass issues three mass-offset products and twelve partial products per stored
// point, and the centroid takes three divisions through the bit-serial divider, skipped when the
// total mass is zero. Points beyond MAX_SOURCES are dropped and flagged. The buffer needs no
// clearing after reset. The input is not ready while a set is being finished; a finished result
// waits in its output register while the next set loads.
`default_nettype none
module point_mass_quadrupole_moment
    import pmqm_pkg::*;
#(
    parameter int MAX_SOURCES = 256,
    parameter int DIMENSIONS  = 3
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // pos_x [23:0], pos_y [47:24], pos_z [71:48], point_mass [95:72]
    input  wire logic [95:0]  s_axis_tdata,
    input  wire logic         s_axis_tlast,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // total_mass [31:0], center_x [55:32], center_y [79:56], center_z [103:80],
    // quad_xx [161:104], quad_xy [219:162], quad_xz [277:220], quad_yy [335:278],
    // quad_yz [393:336], quad_zz [451:394], zero fill [455:452]
    output logic [455:0]      m_axis_tdata,
    // status [1:0]
    output logic [1:0]        m_axis_tuser
);

    localparam int AW = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
    localparam int CW = $clog2(MAX_SOURCES + 1);
    localparam logic [CW-1:0] MAX_CNT   = CW'(MAX_SOURCES);
    localparam logic [3:0]    STEP_WEND = 4'd2;
    localparam logic [3:0]    STEP_U    = 4'd3;
    localparam logic [3:0]    STEP_QEND = 4'd14;

    // Input fields; z is forced to zero for planar sets.
    logic [POS_W-1:0]  in_pos [3];
    logic [MASS_W-1:0] in_m;
    logic              in_acc;
    logic              full;

    assign in_pos[0] = s_axis_tdata[23:0];
    assign in_pos[1] = s_axis_tdata[47:24];
    assign in_pos[2] = (DIMENSIONS > 2) ? s_axis_tdata[71:48] : '0;
    assign in_m      = s_axis_tdata[95:72];
    assign in_acc    = s_axis_tvalid && s_axis_tready;

    t_state r_state, n_state;
    logic [3:0]        r_step;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_idx;
    logic [SUM_W-1:0]  r_mass;
    logic [WSUM_W-1:0] r_w [3];
    logic              r_ovf;
    logic              r_is_last;
    logic [POS_W-1:0]  r_in_pos [3];
    logic [MASS_W-1:0] r_in_m;
    logic [POS_W-1:0]  r_c [3];
    logic [1:0]        r_axis;
    logic              r_div_busy;
    logic [48:0]       r_u [3];
    logic [QUAD_W-1:0] r_q [6];
    logic              r_out_valid;
    logic [SUM_W-1:0]  r_out_mass;
    logic [POS_W-1:0]  r_out_c [3];
    logic [QUAD_W-1:0] r_out_q [6];
    logic [1:0]        r_out_stat;

    // Source buffer, one array per field.
    logic [POS_W-1:0]  mem_x [MAX_SOURCES];
    logic [POS_W-1:0]  mem_y [MAX_SOURCES];
    logic [POS_W-1:0]  mem_z [MAX_SOURCES];
    logic [MASS_W-1:0] mem_m [MAX_SOURCES];
    logic [POS_W-1:0]  r_rd_pos [3];
    logic [MASS_W-1:0] r_rd_m;
    logic              rd_en;

    assign full = (r_count >= MAX_CNT);

    always_ff @(posedge i_clk) begin
        if (in_acc && !full) begin
            mem_x[r_count[AW-1:0]] <= in_pos[0];
            mem_y[r_count[AW-1:0]] <= in_pos[1];
            mem_z[r_count[AW-1:0]] <= in_pos[2];
            mem_m[r_count[AW-1:0]] <= in_m;
        end
        if (rd_en) begin
            r_rd_pos[0] <= mem_x[r_idx[AW-1:0]];
            r_rd_pos[1] <= mem_y[r_idx[AW-1:0]];
            r_rd_pos[2] <= mem_z[r_idx[AW-1:0]];
            r_rd_m      <= mem_m[r_idx[AW-1:0]];
        end
    end

    // Offsets of the current point from the centroid; they always fit 25 bits.
    logic [24:0] diff [3];
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            diff[a] = {r_rd_pos[a][POS_W-1], r_rd_pos[a]} - {r_c[a][POS_W-1], r_c[a]};
        end
    end

    // Shared multiplier.
    t_mul_req mul_req;
    t_mul_rsp mul_rsp;

    pmqm_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    // Centroid divider.
    logic              div_start;
    logic              div_done;
    logic [POS_W-1:0]  div_quot;

    assign div_start = (r_state == ST_DIV) && (r_mass != '0) && !r_div_busy;

    pmqm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_w[r_axis]),
        .i_divisor  (r_mass),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // Next state and multiplier operand selection.
    logic [3:0] ps;
    logic [2:0] pk;
    logic [1:0] pa;
    logic [1:0] pb;

    always_comb begin
        n_state      = r_state;
        rd_en        = 1'b0;
        mul_req.tag  = TAG_NONE;
        mul_req.pair = '0;
        mul_req.op_a = '0;
        mul_req.op_b = '0;
        ps           = r_step - STEP_U;
        pk           = ps[3:1];
        pa           = pair_a(pk);
        pb           = pair_b(pk);
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (!full)             n_state = ST_WMUL;
                    else if (s_axis_tlast) n_state = ST_DIV;
                end
            end
            ST_WMUL: begin
                mul_req.op_b = {2'b00, r_in_m};
                case (r_step)
                    4'd0: begin
                        mul_req.tag  = TAG_WX;
                        mul_req.op_a = OP_W'($signed(r_in_pos[0]));
                    end
                    4'd1: begin
                        mul_req.tag  = TAG_WY;
                        mul_req.op_a = OP_W'($signed(r_in_pos[1]));
                    end
                    default: begin
                        mul_req.tag  = TAG_WZ;
                        mul_req.op_a = OP_W'($signed(r_in_pos[2]));
                    end
                endcase
                if (r_step == STEP_WEND) n_state = ST_WDRAIN;
            end
            ST_WDRAIN: begin
                n_state = r_is_last ? ST_DIV : ST_IDLE;
            end
            ST_DIV: begin
                if (r_mass == '0)                      n_state = ST_QREAD;
                else if (div_done && r_axis == 2'd2)   n_state = ST_QREAD;
            end
            ST_QREAD: begin
                rd_en   = (r_count != '0);
                n_state = (r_count != '0) ? ST_QRUN : ST_QDRAIN;
            end
            ST_QRUN: begin
                if (r_step < STEP_U) begin
                    mul_req.op_b = {2'b00, r_rd_m};
                    case (r_step)
                        4'd0: begin
                            mul_req.tag  = TAG_UX;
                            mul_req.op_a = OP_W'($signed(diff[0]));
                        end
                        4'd1: begin
                            mul_req.tag  = TAG_UY;
                            mul_req.op_a = OP_W'($signed(diff[1]));
                        end
                        default: begin
                            mul_req.tag  = TAG_UZ;
                            mul_req.op_a = OP_W'($signed(diff[2]));
                        end
                    endcase
                end else begin
                    // (offset_a * mass) split at bit 24, each half times offset_b.
                    mul_req.pair = pk;
                    mul_req.op_b = OP_W'($signed(diff[pb]));
                    if (ps[0]) begin
                        mul_req.tag  = TAG_LO;
                        mul_req.op_a = {2'b00, r_u[pa][23:0]};
                    end else begin
                        mul_req.tag  = TAG_HI;
                        mul_req.op_a = OP_W'($signed(r_u[pa][48:24]));
                    end
                end
                if (r_step == STEP_QEND) begin
                    if (r_idx < r_count) rd_en = 1'b1;
                    else                 n_state = ST_QDRAIN;
                end
            end
            ST_QDRAIN: begin
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (!r_out_valid) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_mass      <= '0;
            r_ovf       <= 1'b0;
            r_is_last   <= 1'b0;
            r_axis      <= '0;
            r_div_busy  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state != ST_DIV) begin
                r_axis     <= '0;
                r_div_busy <= 1'b0;
            end else begin
                if (div_start) r_div_busy <= 1'b1;
                if (div_done) begin
                    r_div_busy <= 1'b0;
                    r_axis     <= r_axis + 2'd1;
                end
            end
            if (in_acc) begin
                r_is_last <= s_axis_tlast;
                r_step    <= '0;
                if (!full) begin
                    r_count <= r_count + 1'b1;
                    r_mass  <= r_mass + SUM_W'(in_m);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (r_state == ST_WMUL) r_step <= r_step + 4'd1;
            if (r_state == ST_QREAD) begin
                r_step <= '0;
                r_idx  <= r_idx + 1'b1;
            end
            if (r_state == ST_DIV) r_idx <= '0;
            if (r_state == ST_QRUN) begin
                if (r_step == STEP_QEND) begin
                    r_step <= '0;
                    if (rd_en) r_idx <= r_idx + 1'b1;
                end else begin
                    r_step <= r_step + 4'd1;
                end
            end
            if (r_state == ST_FIN && !r_out_valid) begin
                r_out_valid <= 1'b1;
                r_count     <= '0;
                r_mass      <= '0;
                r_ovf       <= 1'b0;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Weighted sums live with the set and are cleared with it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) r_w[a] <= '0;
        end else if (r_state == ST_FIN && !r_out_valid) begin
            for (int a = 0; a < 3; a++) r_w[a] <= '0;
        end else begin
            case (mul_rsp.tag)
                TAG_WX:  r_w[0] <= r_w[0] + WSUM_W'($signed(mul_rsp.prod));
                TAG_WY:  r_w[1] <= r_w[1] + WSUM_W'($signed(mul_rsp.prod));
                TAG_WZ:  r_w[2] <= r_w[2] + WSUM_W'($signed(mul_rsp.prod));
                default: ;
            endcase
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            for (int a = 0; a < 3; a++) r_in_pos[a] <= in_pos[a];
            r_in_m <= in_m;
        end
        if (r_state == ST_DIV) begin
            if (r_mass == '0) begin
                for (int a = 0; a < 3; a++) r_c[a] <= '0;
            end else if (div_done) begin
                r_c[r_axis] <= div_quot;
            end
        end
        if (r_state == ST_DIV) begin
            for (int k = 0; k < 6; k++) r_q[k] <= '0;
        end else begin
            case (mul_rsp.tag)
                TAG_UX: r_u[0] <= mul_rsp.prod[48:0];
                TAG_UY: r_u[1] <= mul_rsp.prod[48:0];
                TAG_UZ: r_u[2] <= mul_rsp.prod[48:0];
                TAG_HI: begin
                    r_q[mul_rsp.pair] <= r_q[mul_rsp.pair]
                                         + QUAD_W'($signed(mul_rsp.prod));
                end
                TAG_LO: begin
                    r_q[mul_rsp.pair] <= r_q[mul_rsp.pair]
                                         + QUAD_W'($signed(mul_rsp.prod[PROD_W-1:24]));
                end
                default: ;
            endcase
        end
        if (r_state == ST_FIN && !r_out_valid) begin
            r_out_mass <= r_mass;
            for (int a = 0; a < 3; a++) r_out_c[a] <= r_c[a];
            for (int k = 0; k < 6; k++) r_out_q[k] <= r_q[k];
            if (r_mass == '0)  r_out_stat <= STAT_ZERO_MASS;
            else if (r_ovf)    r_out_stat <= STAT_OVERFLOW;
            else               r_out_stat <= STAT_OK;
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_q[5], r_out_q[4], r_out_q[3], r_out_q[2],
                            r_out_q[1], r_out_q[0], r_out_c[2], r_out_c[1], r_out_c[0],
                            r_out_mass};
    assign m_axis_tuser  = r_out_stat;

    // The fill count never passes the buffer depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_CNT)
        else $error("source count beyond buffer depth");

    // A zero-mass result carries a zero centroid.
    a_zero_center: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == STAT_ZERO_MASS) |->
        (m_axis_tdata[103:32] == '0))
        else $error("zero-mass result with nonzero centroid");

    // The divider finishes only while the sequencer waits on it.
    a_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV))
        else $error("divider finished outside the centroid phase");

    // Quadrupole partial products come only from the moment pass.
    a_pair_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mul_rsp.tag == TAG_HI || mul_rsp.tag == TAG_LO) |-> ($past(r_state) == ST_QRUN))
        else $error("quadrupole product outside the moment pass");

endmodule
`default_nettype wire

// ----- rtl/pmqm_mul.sv -----
// Shared signed 26 x 26 multiplier with a registered product and result tag.
`default_nettype none
module pmqm_mul
    import pmqm_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_mul_req i_req,
    output t_mul_rsp      o_rsp
);

    t_tag              r_tag;
    logic [2:0]        r_pair;
    logic [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= TAG_NONE;
        end else begin
            r_tag <= i_req.tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pair <= i_req.pair;
        r_prod <= PROD_W'($signed(i_req.op_a) * $signed(i_req.op_b));
    end

    assign o_rsp.tag  = r_tag;
    assign o_rsp.pair = r_pair;
    assign o_rsp.prod = r_prod;

endmodule
`default_nettype wire

// ----- rtl/pmqm_div.sv -----
// Bit-serial signed-by-unsigned divider with truncation toward zero and 24-bit saturation.
`default_nettype none
module pmqm_div
    import pmqm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [WSUM_W-1:0] i_dividend,
    input  wire logic [SUM_W-1:0]  i_divisor,
    output logic                   o_done,
    output logic [POS_W-1:0]       o_quot
);

    logic              r_busy;
    logic              r_done;
    logic [5:0]        r_cnt;
    logic              r_neg;
    logic [SUM_W-1:0]  r_dvs;
    logic [SUM_W-1:0]  r_rem;
    logic [WSUM_W-1:0] r_quo;

    logic [SUM_W:0]    rem_sh;
    logic              ge;
    logic [SUM_W:0]    rem_sub;

    assign rem_sh  = {r_rem, r_quo[WSUM_W-1]};
    assign ge      = rem_sh >= {1'b0, r_dvs};
    assign rem_sub = rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(WSUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[WSUM_W-1];
            r_quo <= i_dividend[WSUM_W-1] ? (~i_dividend + 1'b1) : i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? rem_sub[SUM_W-1:0] : rem_sh[SUM_W-1:0];
            r_quo <= {r_quo[WSUM_W-2:0], ge};
        end
    end

    always_comb begin
        if (r_neg) begin
            if (r_quo > WSUM_W'(24'h800000)) o_quot = 24'h800000;
            else                             o_quot = ~r_quo[POS_W-1:0] + 1'b1;
        end else begin
            if (r_quo > WSUM_W'(24'h7FFFFF)) o_quot = 24'h7FFFFF;
            else                             o_quot = r_quo[POS_W-1:0];
        end
    end

    assign o_done = r_done;

endmodule
`default_nettype wire
